>>> src/gte_pkg.sv
// shared types, constants and helper functions for the gradient edge map
`timescale 1ns / 1ps
package gte_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH    = 9'd256;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT   = 9'd256;
  localparam logic [GRAY_W-1:0] RST_EDGE_THRESHOLD = 8'd40;

  localparam logic [DIM_W-1:0] MIN_DIM = 9'd2;

  // floor(x / 3) as (x * 683) >> 11, exact for x <= 765
  localparam int unsigned RECIP_3     = 683;
  localparam int unsigned RECIP_SHIFT = 11;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last_col;
    logic               last_row;
    logic               fwd;
    logic [GRAY_W-1:0]  fwd_gray;
  } s1_item_t;

  typedef struct packed {
    logic               adv;
    logic               wr_en;
    logic [COORD_W-1:0] wr_col;
    logic [GRAY_W-1:0]  wr_gray;
  } back_stat_t;

  function automatic logic [GRAY_W-1:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(r) + 10'(g) + 10'(b);
    prod = 20'(sum) * 20'(RECIP_3);
    return prod[RECIP_SHIFT +: GRAY_W];
  endfunction

  function automatic logic [GRAY_W-1:0] abs_diff(input logic [GRAY_W-1:0] a,
                                                 input logic [GRAY_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    res = v;
    if (v < MIN_DIM) begin
      res = MIN_DIM;
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

>>> src/gradient_threshold_edge_map.sv
// top level of the streaming gradient threshold edge map
// Takes one RGB pixel per clock in raster order while in_ready is high and returns edge
// results one row late: the pixel at (row r, col c) settles the result for (r-1, c), and
// a pixel of the last row also yields its own result right after, so such pixels give
// two results. Sustained rate is one pixel per clock outside the last row and output
// stalls, limited by the single read and single write per pixel on the previous-row
// line store. Results pass the input and line-store read registers, then the output
// register. The line store needs no clearing pass after reset. The user must write
// frame geometry and threshold via cfg only while idle; the block does not enforce it.
`timescale 1ns / 1ps
module gradient_threshold_edge_map (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gte_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_red,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gte_pkg::COORD_W-1:0]       out_pixel_row,
  output logic [gte_pkg::COORD_W-1:0]       out_pixel_col,
  output logic                              out_is_white,
  output logic                              out_run_last
);

  gte_pkg::back_stat_t         stat;
  gte_pkg::s1_item_t           s1_item;
  logic                        s1_valid;
  logic [gte_pkg::GRAY_W-1:0]  edge_threshold;
  logic                        rd_en;
  logic [gte_pkg::COORD_W-1:0] rd_addr;
  logic [gte_pkg::GRAY_W-1:0]  rd_data;

  gte_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .stat           (stat),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item),
    .edge_threshold (edge_threshold),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr)
  );

  gte_line_store u_line (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (stat.wr_en),
    .wr_addr (stat.wr_col),
    .wr_data (stat.wr_gray)
  );

  gte_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item),
    .edge_threshold (edge_threshold),
    .rd_data        (rd_data),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_row  (out_pixel_row),
    .out_pixel_col  (out_pixel_col),
    .out_is_white   (out_is_white),
    .out_run_last   (out_run_last)
  );

endmodule

>>> src/gte_line_store.sv
// previous-row gray line store, one write and one registered read per cycle
`timescale 1ns / 1ps
module gte_line_store (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [gte_pkg::COORD_W-1:0]       rd_addr,
  output logic [gte_pkg::GRAY_W-1:0]        rd_data,
  input  logic                              wr_en,
  input  logic [gte_pkg::COORD_W-1:0]       wr_addr,
  input  logic [gte_pkg::GRAY_W-1:0]        wr_data
);

  logic [gte_pkg::GRAY_W-1:0] mem [gte_pkg::MAX_WIDTH];
  logic [gte_pkg::GRAY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/gte_front.sv
// config registers, raster position tracking and the input register stage
`timescale 1ns / 1ps
module gte_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gte_pkg::DIM_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_red,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_blue,
  input  gte_pkg::back_stat_t               stat,
  output logic                              s1_valid,
  output gte_pkg::s1_item_t                 s1_item,
  output logic [gte_pkg::GRAY_W-1:0]        edge_threshold,
  output logic                              rd_en,
  output logic [gte_pkg::COORD_W-1:0]       rd_addr
);

  logic [gte_pkg::DIM_W-1:0]   frame_width_r;
  logic [gte_pkg::DIM_W-1:0]   frame_height_r;
  logic [gte_pkg::GRAY_W-1:0]  edge_threshold_r;
  logic [gte_pkg::COORD_W-1:0] col_pos_r, col_pos_nxt;
  logic [gte_pkg::COORD_W-1:0] row_pos_r, row_pos_nxt;
  logic                        s1_valid_r;
  gte_pkg::s1_item_t           s1_item_r;
  logic [gte_pkg::DIM_W-1:0]   w_eff, h_eff;
  logic                        last_col, last_row, accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= gte_pkg::RST_FRAME_WIDTH;
      frame_height_r   <= gte_pkg::RST_FRAME_HEIGHT;
      edge_threshold_r <= gte_pkg::RST_EDGE_THRESHOLD;
    end else if (cfg_valid) begin
      case (cfg_index)
        gte_pkg::REG_FRAME_WIDTH:    frame_width_r    <= cfg_data;
        gte_pkg::REG_FRAME_HEIGHT:   frame_height_r   <= cfg_data;
        gte_pkg::REG_EDGE_THRESHOLD: edge_threshold_r <= cfg_data[gte_pkg::GRAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign edge_threshold = edge_threshold_r;

  always_comb begin
    w_eff    = gte_pkg::clamp_dim(frame_width_r, gte_pkg::DIM_W'(gte_pkg::MAX_WIDTH));
    h_eff    = gte_pkg::clamp_dim(frame_height_r, gte_pkg::DIM_W'(gte_pkg::MAX_HEIGHT));
    last_col = {1'b0, col_pos_r} >= (w_eff - 9'd1);
    last_row = {1'b0, row_pos_r} >= (h_eff - 9'd1);
    rd_addr  = last_col ? '0 : (col_pos_r + 8'd1);
    in_ready = !s1_valid_r || stat.adv;
    accept   = in_valid && in_ready;
    rd_en    = accept;
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (accept) begin
      if (last_col) begin
        col_pos_nxt = '0;
        row_pos_nxt = last_row ? '0 : (row_pos_r + 8'd1);
      end else begin
        col_pos_nxt = col_pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (stat.adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // line store write of the leaving pixel lands in the read cycle: bypass it
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.red      <= in_red;
      s1_item_r.green    <= in_green;
      s1_item_r.blue     <= in_blue;
      s1_item_r.col      <= col_pos_r;
      s1_item_r.row      <= row_pos_r;
      s1_item_r.last_col <= last_col;
      s1_item_r.last_row <= last_row;
      s1_item_r.fwd      <= stat.wr_en && (stat.wr_col == rd_addr);
      s1_item_r.fwd_gray <= stat.wr_gray;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

>>> src/gte_back.sv
// gray conversion, edge decision, result sequencing and output register
`timescale 1ns / 1ps
module gte_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s1_valid,
  input  gte_pkg::s1_item_t                 s1_item,
  input  logic [gte_pkg::GRAY_W-1:0]        edge_threshold,
  input  logic [gte_pkg::GRAY_W-1:0]        rd_data,
  output gte_pkg::back_stat_t               stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gte_pkg::COORD_W-1:0]       out_pixel_row,
  output logic [gte_pkg::COORD_W-1:0]       out_pixel_col,
  output logic                              out_is_white,
  output logic                              out_run_last
);

  logic [gte_pkg::GRAY_W-1:0]  gray, right, above;
  logic [gte_pkg::GRAY_W-1:0]  gray_above_right_r;
  logic                        phase_r;
  logic                        out_valid_r;
  logic [gte_pkg::COORD_W-1:0] out_row_r, out_col_r;
  logic                        out_white_r, out_last_r;
  logic                        a_valid, b_valid, a_white, b_white;
  logic                        out_free, push, adv, sel_a;
  logic [gte_pkg::COORD_W-1:0] push_row;
  logic                        push_white, push_last;

  always_comb begin
    gray  = gte_pkg::gray_of(s1_item.red, s1_item.green, s1_item.blue);
    right = s1_item.fwd ? s1_item.fwd_gray : rd_data;
    above = gray_above_right_r;

    // result for the pixel above, and the last-row pixel itself
    a_valid = s1_item.row != '0;
    b_valid = s1_item.last_row;
    if (s1_item.last_col) begin
      a_white = above != '0;
    end else begin
      a_white = !((gte_pkg::abs_diff(above, right) >= edge_threshold) ||
                  (gte_pkg::abs_diff(above, gray) >= edge_threshold));
    end
    b_white = gray != '0;

    out_free = !out_valid_r || out_ready;
    sel_a    = a_valid && !phase_r;
    push     = s1_valid && out_free && (a_valid || b_valid);
    adv      = s1_valid && ((!a_valid && !b_valid) ||
                            (out_free && (!(a_valid && b_valid) || phase_r)));

    push_row   = sel_a ? (s1_item.row - 8'd1) : s1_item.row;
    push_white = sel_a ? a_white : b_white;
    push_last  = !(sel_a && b_valid);

    stat.adv     = adv;
    stat.wr_en   = adv;
    stat.wr_col  = s1_item.col;
    stat.wr_gray = gray;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_above_right_r <= '0;
      phase_r            <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      if (adv) begin
        gray_above_right_r <= right;
        phase_r            <= 1'b0;
      end else if (push) begin
        phase_r <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_row_r   <= push_row;
      out_col_r   <= s1_item.col;
      out_white_r <= push_white;
      out_last_r  <= push_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_row = out_row_r;
  assign out_pixel_col = out_col_r;
  assign out_is_white  = out_white_r;
  assign out_run_last  = out_last_r;

endmodule

>>> src/gte_checker.sv
// port-level checker for the gradient edge map, bound to the top level
`timescale 1ns / 1ps
module gte_props (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [gte_pkg::COORD_W-1:0]       out_pixel_row,
  input  logic [gte_pkg::COORD_W-1:0]       out_pixel_col,
  input  logic                              out_is_white,
  input  logic                              out_run_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_row) &&
      $stable(out_pixel_col) && $stable(out_is_white) && $stable(out_run_last))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // second result of a last-row pixel follows at once, one row lower, same column
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=> out_valid &&
      out_pixel_col == $past(out_pixel_col) &&
      out_pixel_row == ($past(out_pixel_row) + 8'd1) && out_run_last)
    else $error("broken result pair");

  // config channel always takes a request
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config request refused");

endmodule

bind gradient_threshold_edge_map gte_props u_chk (.*);

>>> tb/gte_checker.sv
// checker for the edge map: tracks the registers, predicts the results of each pixel and compares
`timescale 1ns / 1ps
module gte_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [gte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gte_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [gte_pkg::COORD_W-1:0]   out_pixel_row,
  input  logic [gte_pkg::COORD_W-1:0]   out_pixel_col,
  input  logic                          out_is_white,
  input  logic                          out_run_last,
  output int                            mismatches,
  output int                            outstanding,
  output int                            results_seen,
  output logic                          at_frame_start,
  output int                            frame_left
);
  import gte_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               white;
    logic               last;
  } edge_result_t;

  edge_result_t      results_due[$];
  logic [GRAY_W-1:0] line_gray[MAX_WIDTH];
  logic [GRAY_W-1:0] upper_right;
  int unsigned       col_now;
  int unsigned       row_now;
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [GRAY_W-1:0] thresh_reg;
  int                errs = 0;
  int                seen = 0;

  function automatic int unsigned dim_in_range(input logic [DIM_W-1:0] v, input int unsigned hi);
    int unsigned d;
    d = v;
    if (d < 2) begin
      d = 2;
    end else if (d > hi) begin
      d = hi;
    end
    return d;
  endfunction

  task automatic flag_mismatch(input string what);
    errs++;
    if (errs <= 10) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned       w;
    int unsigned       h;
    int unsigned       rd;
    logic [9:0]        sum;
    logic [GRAY_W-1:0] gray;
    logic [GRAY_W-1:0] target;
    logic [GRAY_W-1:0] right;
    int                d_right;
    int                d_below;
    logic              lc;
    logic              lr;
    edge_result_t      res;
    w = dim_in_range(width_reg, MAX_WIDTH);
    h = dim_in_range(height_reg, MAX_HEIGHT);
    sum = 10'(r) + 10'(g) + 10'(b);
    gray = 8'(sum / 10'd3);
    lc = (col_now >= w - 1);
    lr = (row_now >= h - 1);
    rd = lc ? 0 : col_now + 1;
    right = (rd < MAX_WIDTH) ? line_gray[rd] : '0;
    // pixel one row up is decided now, its lower neighbor is the incoming gray
    target = upper_right;
    if (row_now >= 1) begin
      d_right = (target > right) ? target - right : right - target;
      d_below = (target > gray) ? target - gray : gray - target;
      res.row = 8'(row_now - 1);
      res.col = 8'(col_now);
      res.white = lc ? (target != 0) : !(d_right >= thresh_reg || d_below >= thresh_reg);
      res.last = !lr;
      results_due.push_back(res);
    end
    if (lr) begin
      res.row = 8'(row_now);
      res.col = 8'(col_now);
      res.white = (gray != 0);
      res.last = 1'b1;
      results_due.push_back(res);
    end
    if (col_now < MAX_WIDTH) begin
      line_gray[col_now] = gray;
    end
    upper_right = right;
    if (lc) begin
      col_now = 0;
      row_now = lr ? 0 : row_now + 1;
    end else begin
      col_now = col_now + 1;
    end
  endtask

  always @(posedge clk) begin : watch
    edge_result_t got;
    edge_result_t want;
    int unsigned  w;
    int unsigned  h;
    if (!rst_n) begin
      results_due.delete();
      foreach (line_gray[i]) line_gray[i] = '0;
      upper_right = '0;
      col_now = 0;
      row_now = 0;
      width_reg = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      thresh_reg = RST_EDGE_THRESHOLD;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:    width_reg = cfg_data;
          REG_FRAME_HEIGHT:   height_reg = cfg_data;
          REG_EDGE_THRESHOLD: thresh_reg = cfg_data[GRAY_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen++;
        got = {out_pixel_row, out_pixel_col, out_is_white, out_run_last};
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: row %0d col %0d white %0b last %0b",
                                  got.row, got.col, got.white, got.last));
        end else begin
          want = results_due.pop_front();
          if (got.row !== want.row || got.col !== want.col || got.white !== want.white ||
              got.last !== want.last) begin
            flag_mismatch($sformatf({"expected row %0d col %0d white %0b last %0b, ",
                                     "got row %0d col %0d white %0b last %0b"},
                                    want.row, want.col, want.white, want.last,
                                    got.row, got.col, got.white, got.last));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_pixel(in_red, in_green, in_blue);
      end
    end
    w = dim_in_range(width_reg, MAX_WIDTH);
    h = dim_in_range(height_reg, MAX_HEIGHT);
    mismatches <= errs;
    outstanding <= results_due.size();
    results_seen <= seen;
    at_frame_start <= (col_now == 0 && row_now == 0);
    frame_left <= ((row_now >= h - 1) ? 0 : (h - 1 - row_now) * w) +
                  ((col_now >= w - 1) ? 1 : w - col_now);
  end

endmodule

>>> tb/tb_gradient_threshold_edge_map.sv
// testbench top for the gradient threshold edge map: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_gradient_threshold_edge_map;
  import gte_pkg::*;

  localparam int PIXEL_TARGET  = 650;
  localparam int LONG_HOLD     = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG_INDEX = 2'd3;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_red = '0;
  logic [7:0]           in_green = '0;
  logic [7:0]           in_blue = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   out_pixel_row;
  logic [COORD_W-1:0]   out_pixel_col;
  logic                 out_is_white;
  logic                 out_run_last;

  int   mismatches;
  int   outstanding;
  int   results_seen;
  int   frame_left;
  logic at_frame_start;

  int   pixels_sent = 0;
  int   cfg_writes = 0;
  int   width_eff = MAX_WIDTH;
  int   stall_asks = 0;
  int   stall_done = 0;
  logic sender_calm = 1'b0;

  gradient_threshold_edge_map u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_row (out_pixel_row),
    .out_pixel_col (out_pixel_col),
    .out_is_white  (out_is_white),
    .out_run_last  (out_run_last)
  );

  gte_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_row  (out_pixel_row),
    .out_pixel_col  (out_pixel_col),
    .out_is_white   (out_is_white),
    .out_run_last   (out_run_last),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .at_frame_start (at_frame_start),
    .frame_left     (frame_left)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: per-result hold-offs, calm stretches, and one long hold on request
  initial begin : result_sink
    int   hold;
    int   taken;
    logic calm;
    taken = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_asks != stall_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        stall_done = stall_done + 1;
      end else if (out_valid && out_ready) begin
        taken++;
        if (taken % 50 == 0) begin
          calm = ($urandom_range(0, 2) == 0);
        end
        hold = calm ? 0 : $urandom_range(0, 13);
        if (hold > 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic int span_of(input logic [DIM_W-1:0] v);
    return (v < MIN_DIM) ? MIN_DIM : (v > MAX_WIDTH) ? MAX_WIDTH : v;
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    if (idx == REG_FRAME_WIDTH) begin
      width_eff = span_of(data);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // row-0 pixels give no result, so let the pipeline drain after the queue empties
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic [DIM_W-1:0] w_pick;
    logic [DIM_W-1:0] h_pick;
    logic [7:0]       t_pick;
    int               count;
    int               phase;
    int               v;
    int               base;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry, row 0 only
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd0);
    wait_idle();

    // narrow below the current column, heights and widths under the minimum
    write_reg(REG_FRAME_WIDTH, 9'd1);
    write_reg(REG_FRAME_HEIGHT, 9'd0);
    write_reg(REG_EDGE_THRESHOLD, 9'd0);
    send_pixel(8'd255, 8'd255, 8'd254);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd1);
    send_pixel(8'd3, 8'd3, 8'd2);
    send_pixel(8'd0, 8'd0, 8'd255);
    wait_idle();

    write_reg(REG_EDGE_THRESHOLD, 9'h1ff);
    write_reg(REG_FRAME_WIDTH, 9'd2);
    write_reg(REG_FRAME_HEIGHT, 9'd1);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    wait_idle();

    // oversized geometry at a frame start
    write_reg(REG_FRAME_WIDTH, 9'd511);
    write_reg(REG_FRAME_HEIGHT, 9'd300);
    write_reg(REG_EDGE_THRESHOLD, 9'd40);
    send_pixel(8'd100, 8'd100, 8'd100);
    send_pixel(8'd140, 8'd140, 8'd140);
    send_pixel(8'd60, 8'd60, 8'd60);
    send_pixel(8'd100, 8'd100, 8'd100);
    wait_idle();

    write_reg(REG_FRAME_WIDTH, 9'd3);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd140, 8'd140, 8'd141);
    send_pixel(8'd100, 8'd100, 8'd99);
    send_pixel(8'd0, 8'd1, 8'd1);
    wait_idle();

    // shrink height below the current row, and touch the unused index
    write_reg(REG_FRAME_HEIGHT, 9'd2);
    write_reg(SPARE_REG_INDEX, 9'h155);
    send_pixel(8'd0, 8'd0, 8'd2);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd200);

    phase = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      wait_idle();
      phase++;
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 19))
          0:       w_pick = 9'($urandom_range(0, 1));
          1:       w_pick = 9'($urandom_range(257, 511));
          2:       w_pick = 9'd256;
          default: w_pick = 9'($urandom_range(2, 12));
        endcase
        // widening mid-frame would read line entries never written
        if (span_of(w_pick) <= width_eff || at_frame_start) begin
          write_reg(REG_FRAME_WIDTH, w_pick);
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 19))
          0:       h_pick = 9'($urandom_range(0, 1));
          1:       h_pick = 9'($urandom_range(257, 511));
          2:       h_pick = 9'd256;
          default: h_pick = 9'($urandom_range(2, 8));
        endcase
        write_reg(REG_FRAME_HEIGHT, h_pick);
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 7))
          0:       t_pick = 8'd0;
          1:       t_pick = 8'd255;
          2:       t_pick = 8'($urandom);
          default: t_pick = 8'($urandom_range(1, 60));
        endcase
        write_reg(REG_EDGE_THRESHOLD, {1'($urandom_range(0, 1)), t_pick});
      end
      sender_calm = ($urandom_range(0, 3) == 0);
      base = $urandom_range(0, 255);
      if (phase == 3) begin
        sender_calm = 1'b1;
        stall_asks <= stall_asks + 1;
        count = 60;
      end else if (frame_left <= 80 && $urandom_range(0, 1) == 1) begin
        count = frame_left;
      end else begin
        count = $urandom_range(5, 40);
      end
      repeat (count) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
          end
          4: begin
            r = $urandom_range(0, 1) ? 8'hff : 8'h00;
            g = $urandom_range(0, 1) ? 8'hff : 8'h00;
            b = $urandom_range(0, 1) ? 8'hff : 8'h00;
          end
          5: begin
            r = 8'($urandom_range(0, 1));
            g = 8'($urandom_range(0, 1));
            b = 8'($urandom_range(0, 1));
          end
          default: begin
            // near the phase's base level, to land close to the threshold
            v = base + int'($urandom_range(0, 48)) - 24;
            if (v < 0) begin
              v = 0;
            end else if (v > 255) begin
              v = 255;
            end
            r = 8'(v);
            g = 8'(v);
            b = 8'(v) ^ 8'($urandom_range(0, 3));
          end
        endcase
        send_pixel(r, g, b);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d pixels, %0d results and %0d register writes", pixels_sent,
             results_seen, cfg_writes);
    $display("frames from 2 to 256 wide and high, thresholds 0 to 255, stalls on both sides");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
